// ===== src/tlik_pkg.sv =====
// Shared types and constants for the two-link leg inverse kinematics block.
// No dependencies; imported by every module of the block.
package tlik_pkg;

  localparam int IN_W      = 16;
  localparam int LEN_W     = 15;
  localparam int OUT_W     = 17;
  localparam int RAD_W     = 32;
  localparam int ROOT_W    = 16;
  localparam int ISQ_STEPS = 16;
  localparam int CIN_W     = 36;
  localparam int CW        = 38;
  localparam int ZW        = 35;
  localparam int ANG_W     = 36;
  localparam int TAB_LEN   = 24;
  localparam int TAB_W     = 30;
  localparam int K_W       = 28;
  localparam int PROD_W    = 64;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int SQ_W      = 30;

  localparam logic [1:0] REG_UPPER  = 2'd0;
  localparam logic [1:0] REG_LOWER  = 2'd1;
  localparam logic [1:0] REG_MIRROR = 2'd2;

  localparam logic signed [ZW-1:0]  PI_Q30 = 35'sd3373259426;
  localparam logic signed [K_W-1:0] K_Q24  = 28'sd96126367;

  localparam logic [TAB_W-1:0] ATAN_TAB [TAB_LEN] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
  };

  typedef struct packed {
    logic                   unr;
    logic                   mir;
    logic [SQ_W-1:0]        l1sq;
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
  } side_t;

  typedef struct packed {
    logic unr;
    logic mir;
  } flag_t;

endpackage

// ===== src/tlik_isqrt.sv =====
// Pipelined floor square root, one result bit per register stage.
// Depends on tlik_pkg.
module tlik_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [tlik_pkg::RAD_W-1:0]  rad_i,
  output logic                        vld_o,
  output logic [tlik_pkg::ROOT_W-1:0] root_o
);
  import tlik_pkg::*;

  logic [RAD_W-1:0] rem_q [ISQ_STEPS+1];
  logic [RAD_W-1:0] res_q [ISQ_STEPS+1];
  logic             vld_q [ISQ_STEPS+1];

  assign rem_q[0] = rad_i;
  assign res_q[0] = '0;
  assign vld_q[0] = vld_i;

  for (genvar i = 0; i < ISQ_STEPS; i++) begin : g_stage
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * (ISQ_STEPS - 1 - i));
    logic [RAD_W:0]   trial;
    logic             ge;
    logic [RAD_W-1:0] rem_d;
    logic [RAD_W-1:0] res_d;

    assign trial = {1'b0, res_q[i]} + {1'b0, BIT};
    assign ge    = {1'b0, rem_q[i]} >= trial;
    assign rem_d = ge ? rem_q[i] - trial[RAD_W-1:0] : rem_q[i];
    assign res_d = ge ? (res_q[i] >> 1) + BIT : res_q[i] >> 1;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i+1] <= rem_d;
        res_q[i+1] <= res_d;
      end
    end
  end

  assign vld_o  = vld_q[ISQ_STEPS];
  assign root_o = res_q[ISQ_STEPS][ROOT_W-1:0];

endmodule

// ===== src/tlik_cordic.sv =====
// Pipelined vectoring cordic atan2, one micro-rotation per register stage.
// Depends on tlik_pkg.
module tlik_cordic #(
  parameter int STEPS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic signed [tlik_pkg::CIN_W-1:0] x_i,
  input  logic signed [tlik_pkg::CIN_W-1:0] y_i,
  output logic                              vld_o,
  output logic signed [tlik_pkg::ZW-1:0]    z_o
);
  import tlik_pkg::*;

  logic signed [CW-1:0] x_q [STEPS+1];
  logic signed [CW-1:0] y_q [STEPS+1];
  logic signed [ZW-1:0] z_q [STEPS+1];
  logic                 zero_q [STEPS+1];
  logic                 vld_q [STEPS+1];

  logic signed [CW-1:0] xe;
  logic signed [CW-1:0] ye;
  assign xe = CW'(x_i);
  assign ye = CW'(y_i);

  // quadrant fold: turn left half-plane vectors by pi
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q[0] <= (x_i == '0) && (y_i == '0);
      if (xe[CW-1]) begin
        x_q[0] <= -xe;
        y_q[0] <= -ye;
        z_q[0] <= ye[CW-1] ? -PI_Q30 : PI_Q30;
      end else begin
        x_q[0] <= xe;
        y_q[0] <= ye;
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] ang;

    assign dx  = x_q[i] >>> i;
    assign dy  = y_q[i] >>> i;
    assign ang = signed'(ZW'(ATAN_TAB[i]));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        zero_q[i+1] <= zero_q[i];
        if (!y_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] + dy;
          y_q[i+1] <= y_q[i] - dx;
          z_q[i+1] <= z_q[i] + ang;
        end else begin
          x_q[i+1] <= x_q[i] - dy;
          y_q[i+1] <= y_q[i] + dx;
          z_q[i+1] <= z_q[i] - ang;
        end
      end
    end
  end

  assign vld_o = vld_q[STEPS];
  assign z_o   = zero_q[STEPS] ? '0 : z_q[STEPS];

endmodule

// ===== src/tlik_out_buf.sv =====
// Two-entry result buffer that decouples the pipeline from output stalls.
// Depends on tlik_pkg.
module tlik_out_buf (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic signed [tlik_pkg::OUT_W-1:0] hip_i,
  input  logic signed [tlik_pkg::OUT_W-1:0] knee_i,
  input  logic                             unr_i,
  output logic                             full_o,
  output logic                             valid_o,
  input  logic                             stall_i,
  output logic signed [tlik_pkg::OUT_W-1:0] hip_o,
  output logic signed [tlik_pkg::OUT_W-1:0] knee_o,
  output logic                             unr_o
);
  import tlik_pkg::*;

  logic signed [OUT_W-1:0] hip_q  [2];
  logic signed [OUT_W-1:0] knee_q [2];
  logic                    unr_q  [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop     = valid_o && !stall_i;
  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign wr_d    = push_i ? !wr_q : wr_q;
  assign rd_d    = pop ? !rd_q : rd_q;
  assign cnt_d   = cnt_q + {1'b0, push_i} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      hip_q[wr_q]  <= hip_i;
      knee_q[wr_q] <= knee_i;
      unr_q[wr_q]  <= unr_i;
    end
  end

  assign hip_o  = hip_q[rd_q];
  assign knee_o = knee_q[rd_q];
  assign unr_o  = unr_q[rd_q];

endmodule

// ===== src/two_link_leg_inverse_kinematics.sv =====
// Two-link leg inverse kinematics: foot target in, hip and knee angles out.
// Depends on tlik_pkg, tlik_isqrt, tlik_cordic and tlik_out_buf.
// Takes one target per clock; a result passes CORDIC_STEPS + 25 register stages before it
// shows on the output: squares, radius, reach test, the 16-stage square root, root products,
// hip vector, the cordic chain (one stage per step plus a quadrant fold), joint angles, the
// output scaling and a two-entry result buffer. An output stall holds the whole pipeline, and
// the input with it, only once that buffer is full. Link lengths and the elbow mirror are to
// be written over APB only while no item is in flight; the block does not enforce this.
module two_link_leg_inverse_kinematics #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tlik_pkg::ADDR_W-1:0]       paddr,
  input  logic [tlik_pkg::DATA_W-1:0]       pwdata,
  output logic [tlik_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [tlik_pkg::IN_W-1:0]  target_x_i,
  input  logic signed [tlik_pkg::IN_W-1:0]  target_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [tlik_pkg::OUT_W-1:0] hip_angle_o,
  output logic signed [tlik_pkg::OUT_W-1:0] knee_angle_o,
  output logic                              unreachable_o
);
  import tlik_pkg::*;

  localparam int SH = 54 - FRAC_BITS;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (SH - 1);
  localparam logic signed [PROD_W-1:0] OUT_MAX = PROD_W'(65535);
  localparam logic signed [PROD_W-1:0] OUT_MIN = -PROD_W'(65536);

  // configuration
  logic [LEN_W-1:0] upper_q;
  logic [LEN_W-1:0] lower_q;
  logic             mirror_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q  <= 15'd6451;
      lower_q  <= 15'd6912;
      mirror_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_UPPER:  upper_q  <= pwdata[LEN_W-1:0];
        REG_LOWER:  lower_q  <= pwdata[LEN_W-1:0];
        REG_MIRROR: mirror_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_UPPER:  prdata = DATA_W'(upper_q);
      REG_LOWER:  prdata = DATA_W'(lower_q);
      REG_MIRROR: prdata = DATA_W'(mirror_q);
      default:    prdata = '0;
    endcase
  end

  logic en;
  logic buf_full;
  assign en         = !buf_full;
  assign in_stall_o = !en;

  // stage 1: squares
  logic signed [2*IN_W-1:0] xx_w, yy_w;
  logic [LEN_W:0]           lsum_w;
  logic signed [LEN_W+1:0]  ldif_w;
  logic [RAD_W-1:0]         ss_w;
  logic signed [2*LEN_W+3:0] dd_w;
  logic [SQ_W-1:0]          l1sq_w;

  assign xx_w   = target_x_i * target_x_i;
  assign yy_w   = target_y_i * target_y_i;
  assign lsum_w = {1'b0, upper_q} + {1'b0, lower_q};
  assign ldif_w = signed'({2'b0, upper_q}) - signed'({2'b0, lower_q});
  assign ss_w   = lsum_w * lsum_w;
  assign dd_w   = ldif_w * ldif_w;
  assign l1sq_w = upper_q * upper_q;

  logic                   s1_vld_q;
  logic [RAD_W-1:0]       s1_xx_q, s1_yy_q, s1_ss_q;
  logic [SQ_W-1:0]        s1_dd_q, s1_l1sq_q;
  logic signed [IN_W-1:0] s1_x_q, s1_y_q;
  logic                   s1_mir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_xx_q   <= xx_w;
      s1_yy_q   <= yy_w;
      s1_ss_q   <= ss_w;
      s1_dd_q   <= dd_w[SQ_W-1:0];
      s1_l1sq_q <= l1sq_w;
      s1_x_q    <= target_x_i;
      s1_y_q    <= target_y_i;
      s1_mir_q  <= mirror_q;
    end
  end

  // stage 2: radius squared
  logic                   s2_vld_q;
  logic [RAD_W-1:0]       s2_r2_q, s2_ss_q;
  logic [SQ_W-1:0]        s2_dd_q, s2_l1sq_q;
  logic signed [IN_W-1:0] s2_x_q, s2_y_q;
  logic                   s2_mir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_r2_q   <= s1_xx_q + s1_yy_q;
      s2_ss_q   <= s1_ss_q;
      s2_dd_q   <= s1_dd_q;
      s2_l1sq_q <= s1_l1sq_q;
      s2_x_q    <= s1_x_q;
      s2_y_q    <= s1_y_q;
      s2_mir_q  <= s1_mir_q;
    end
  end

  // stage 3: reach test and radicands
  logic             s3_vld_q;
  logic [RAD_W-1:0] s3_va_q, s3_vb_q;
  side_t            s3_side_q;
  logic [RAD_W-1:0] dd_ext;
  assign dd_ext = RAD_W'(s2_dd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_va_q        <= s2_ss_q - s2_r2_q;
      s3_vb_q        <= s2_r2_q - dd_ext;
      s3_side_q.unr  <= (s2_r2_q > s2_ss_q) || (s2_r2_q < dd_ext);
      s3_side_q.mir  <= s2_mir_q;
      s3_side_q.l1sq <= s2_l1sq_q;
      s3_side_q.x    <= s2_x_q;
      s3_side_q.y    <= s2_y_q;
    end
  end

  // square roots
  logic              sq_vld;
  logic [ROOT_W-1:0] root_a, root_b;

  tlik_isqrt u_isqrt_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s3_vld_q),
    .rad_i  (s3_va_q),
    .vld_o  (sq_vld),
    .root_o (root_a)
  );

  tlik_isqrt u_isqrt_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s3_vld_q),
    .rad_i  (s3_vb_q),
    .vld_o  (),
    .root_o (root_b)
  );

  side_t side_q [ISQ_STEPS];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= s3_side_q;
      for (int i = 1; i < ISQ_STEPS; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // stage 4: products of roots
  logic              s4_vld_q;
  logic [RAD_W-1:0]  s4_aa_q, s4_bb_q, s4_ab_q;
  logic [ROOT_W-1:0] s4_a_q, s4_b_q;
  side_t             s4_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_aa_q   <= root_a * root_a;
      s4_bb_q   <= root_b * root_b;
      s4_ab_q   <= root_a * root_b;
      s4_a_q    <= root_a;
      s4_b_q    <= root_b;
      s4_side_q <= side_q[ISQ_STEPS-1];
    end
  end

  // stage 5: second hip vector
  logic                    s5_vld_q;
  logic signed [CIN_W-1:0] s5_den_q, s5_sn_q;
  logic signed [CIN_W-1:0] s5_a_q, s5_b_q, s5_x_q, s5_y_q;
  flag_t                   s5_flag_q;
  logic signed [CIN_W-1:0] den_w, two_ab_w;

  assign den_w = signed'(CIN_W'({s4_side_q.l1sq, 2'b00}))
               + signed'(CIN_W'(s4_bb_q)) - signed'(CIN_W'(s4_aa_q));
  assign two_ab_w = signed'(CIN_W'({s4_ab_q, 1'b0}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_den_q      <= den_w;
      s5_sn_q       <= s4_side_q.mir ? -two_ab_w : two_ab_w;
      s5_a_q        <= signed'(CIN_W'(s4_a_q));
      s5_b_q        <= signed'(CIN_W'(s4_b_q));
      s5_x_q        <= CIN_W'(s4_side_q.x);
      s5_y_q        <= CIN_W'(s4_side_q.y);
      s5_flag_q.unr <= s4_side_q.unr;
      s5_flag_q.mir <= s4_side_q.mir;
    end
  end

  // angle pipelines
  logic                 cd_vld;
  logic signed [ZW-1:0] z_knee, z_tgt, z_off;

  tlik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_knee (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s5_vld_q),
    .x_i    (s5_b_q),
    .y_i    (s5_a_q),
    .vld_o  (cd_vld),
    .z_o    (z_knee)
  );

  tlik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_tgt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s5_vld_q),
    .x_i    (s5_x_q),
    .y_i    (s5_y_q),
    .vld_o  (),
    .z_o    (z_tgt)
  );

  tlik_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_off (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s5_vld_q),
    .x_i    (s5_den_q),
    .y_i    (s5_sn_q),
    .vld_o  (),
    .z_o    (z_off)
  );

  flag_t flag_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      flag_q[0] <= s5_flag_q;
      for (int i = 1; i <= CORDIC_STEPS; i++) begin
        flag_q[i] <= flag_q[i-1];
      end
    end
  end

  // stage 6: joint angles in radians
  logic                    s6_vld_q;
  logic signed [ANG_W-1:0] s6_hip_q, s6_knee_q;
  logic                    s6_unr_q;
  logic signed [ANG_W-1:0] knee2_w;

  assign knee2_w = ANG_W'(z_knee) <<< 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else if (en) begin
      s6_vld_q <= cd_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_hip_q  <= ANG_W'(z_tgt) - ANG_W'(z_off);
      s6_knee_q <= flag_q[CORDIC_STEPS].mir ? -knee2_w : knee2_w;
      s6_unr_q  <= flag_q[CORDIC_STEPS].unr;
    end
  end

  // stage 7: scale to motor units
  logic                     s7_vld_q;
  logic signed [PROD_W-1:0] s7_hip_q, s7_knee_q;
  logic                     s7_unr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else if (en) begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_hip_q  <= s6_hip_q * K_Q24;
      s7_knee_q <= s6_knee_q * K_Q24;
      s7_unr_q  <= s6_unr_q;
    end
  end

  function automatic logic signed [OUT_W-1:0] sat_out(logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] v;
    v = (prod + HALF) >>> SH;
    if (v > OUT_MAX) begin
      return OUT_W'(OUT_MAX);
    end else if (v < OUT_MIN) begin
      return OUT_W'(OUT_MIN);
    end
    return v[OUT_W-1:0];
  endfunction

  logic signed [OUT_W-1:0] hip_w, knee_w;
  logic                    push;

  assign hip_w  = s7_unr_q ? '0 : sat_out(s7_hip_q);
  assign knee_w = s7_unr_q ? '0 : sat_out(s7_knee_q);
  assign push   = s7_vld_q && en;

  tlik_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .hip_i   (hip_w),
    .knee_i  (knee_w),
    .unr_i   (s7_unr_q),
    .full_o  (buf_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .hip_o   (hip_angle_o),
    .knee_o  (knee_angle_o),
    .unr_o   (unreachable_o)
  );

  a_unr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unreachable_o |-> hip_angle_o == '0 && knee_angle_o == '0)
    else $error("unreachable item with nonzero angle");

  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en && s7_vld_q |=> s7_vld_q && $stable(s7_hip_q) && $stable(s7_knee_q))
    else $error("last stage changed while buffer full");

  a_full_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_full |-> out_valid_o)
    else $error("buffer full without a result shown");

endmodule
